>>> design/ttuv_pkg.sv
`default_nettype none
package ttuv_pkg;
    localparam int VertexCountDefault = 1024;
    localparam int IndexWidth = 10;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_TRI  = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [IndexWidth-1:0]  vertex_index;
        logic signed [15:0]     pos_x;
        logic signed [15:0]     pos_y;
        logic signed [15:0]     pos_z;
        logic signed [15:0]     tex_u;
        logic signed [15:0]     tex_v;
        logic [IndexWidth-1:0]  index_a;
        logic [IndexWidth-1:0]  index_b;
        logic [IndexWidth-1:0]  index_c;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic               degenerate;
        logic               saturated;
    } result_item_t;
endpackage
`default_nettype wire

>>> design/ttuv_div.sv
`default_nettype none
// signed divider, one quotient bit per cycle, truncating, saturates to 32 bits
module ttuv_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic signed [48:0] num,
    input  wire logic signed [32:0] den,
    output logic                    done,
    output logic signed [31:0]      quo,
    output logic                    sat
);
    // dividend magnitude is num * 2^22, up to 71 bits
    localparam int NW = 71;

    logic [NW-1:0] q_reg, q_next;
    logic [32:0]   r_reg, r_next;
    logic [32:0]   d_reg, d_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          neg_reg, neg_next;
    logic          done_reg, done_next;

    logic [48:0] num_mag;
    logic [32:0] den_mag;
    logic [33:0] trial;
    logic [33:0] shifted;
    logic [NW:0] signed_q;

    assign num_mag = num[48] ? 49'(-num) : 49'(num);
    assign den_mag = den[32] ? 33'(-den) : 33'(den);
    assign shifted = {r_reg, q_reg[NW-1]};
    assign trial   = shifted - {1'b0, d_reg};

    // restoring divide step
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (go)
        begin
            q_next    = {num_mag, 22'd0};
            r_next    = '0;
            d_next    = den_mag;
            cnt_next  = 7'(NW);
            busy_next = 1'b1;
            neg_next  = num[48] ^ den[32];
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[32:0];
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // sign and clip
    assign signed_q = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
    always_comb
    begin
        sat = 1'b0;
        quo = signed_q[31:0];
        if (!neg_reg && (q_reg > NW'(32'h7fffffff)))
        begin
            sat = 1'b1;
            quo = 32'sh7fffffff;
        end
        else if (neg_reg && (q_reg > NW'(33'h080000000)))
        begin
            sat = 1'b1;
            quo = 32'sh80000000;
        end
    end
    assign done = done_reg;

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> !busy_reg) else $error("divider restarted while busy");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
`endif
endmodule
`default_nettype wire

>>> design/triangle_tangent_from_uv.sv
`default_nettype none
// load: written to the vertex store, no result. read: result from the tangent store.
// triangle: three vertex reads, det, then per axis a numerator and a 71-step serial
// divide, then three tangent writes; for zero det the divides are skipped and zero tangents written.
// one item at a time (busy); the result strobe lasts one cycle, no stall.
// after reset a clearing pass zeroes the tangent store, busy is high during it.
module triangle_tangent_from_uv #(
    parameter int VERTEX_COUNT = ttuv_pkg::VertexCountDefault
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire ttuv_pkg::req_item_t  req,
    output logic                      busy,
    output logic                      strobe,
    output ttuv_pkg::result_item_t    result
);
    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int RecipShift = 20;
    localparam int Recip = ((1 << RecipShift) + VERTEX_COUNT - 1) / VERTEX_COUNT;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_GET_C, S_DET, S_NUM,
        S_DIV_GO, S_DIV_WAIT, S_WR, S_RD_T
    } state_t;

    // vertex memories
    logic [47:0] pos_mem [VERTEX_COUNT];
    logic [31:0] tex_mem [VERTEX_COUNT];
    logic [95:0] tan_mem [VERTEX_COUNT];

    state_t state_reg;
    logic [AW:0]   clr_reg;
    logic [AW-1:0] ia_reg, ib_reg, ic_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] tan_raddr;
    logic [47:0]   pos_q;
    logic [31:0]   tex_q;
    logic [95:0]   tan_q;
    logic          tan_we;
    logic [AW-1:0] tan_waddr;
    logic [95:0]   tan_wdata;

    logic signed [15:0] pa_reg [3];
    logic signed [15:0] pb_reg [3];
    logic signed [15:0] ua_reg, va_reg, ub_reg, vb_reg;
    logic signed [16:0] d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [32:0] det_reg;
    logic signed [33:0] m1_reg, m2_reg;
    logic signed [48:0] num_reg;
    logic [1:0]         k_reg;
    logic [1:0]         wr_reg;
    logic [1:0]         step_reg;
    logic signed [31:0] t_reg [3];
    logic               sat_reg, degen_reg;
    logic               div_go;
    logic               div_done;
    logic signed [31:0] div_q;
    logic               div_sat;
    logic               strobe_reg;
    ttuv_pkg::result_item_t res_reg;

    // index modulo the store depth by reciprocal multiply
    function automatic logic [AW-1:0] slot(input logic [ttuv_pkg::IndexWidth-1:0] v);
        logic [31:0] prod;
        logic [31:0] w;
        prod = 32'(v) * 32'(Recip);
        w = 32'(v) - (prod >> RecipShift) * 32'(VERTEX_COUNT);
        return w[AW-1:0];
    endfunction

    ttuv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (num_reg),
        .den   (det_reg),
        .done  (div_done),
        .quo   (div_q),
        .sat   (div_sat)
    );

    assign div_go = (state_reg == S_DIV_GO);

    // read address by state
    always_comb
    begin
        unique case (state_reg)
            S_RD_B:  rd_addr = ib_reg;
            S_RD_C:  rd_addr = ic_reg;
            default: rd_addr = ia_reg;
        endcase
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (start && !busy && (req.req_type == ttuv_pkg::REQ_LOAD))
        begin
            pos_mem[slot(req.vertex_index)] <= {req.pos_x, req.pos_y, req.pos_z};
            tex_mem[slot(req.vertex_index)] <= {req.tex_u, req.tex_v};
        end
        pos_q <= pos_mem[rd_addr];
        tex_q <= tex_mem[rd_addr];
    end

    // tangent read address follows the incoming read while idle
    assign tan_raddr = (state_reg == S_IDLE) ? slot(req.vertex_index) : ia_reg;

    always_ff @(posedge clk)
    begin
        if (tan_we)
            tan_mem[tan_waddr] <= tan_wdata;
        tan_q <= tan_mem[tan_raddr];
    end

    // tangent write port
    always_comb
    begin
        tan_we    = 1'b0;
        tan_waddr = ia_reg;
        tan_wdata = {t_reg[0], t_reg[1], t_reg[2]};
        if (state_reg == S_CLEAR)
        begin
            tan_we    = 1'b1;
            tan_waddr = clr_reg[AW-1:0];
            tan_wdata = '0;
        end
        else if (state_reg == S_WR)
        begin
            tan_we = 1'b1;
            unique case (wr_reg)
                2'd0:    tan_waddr = ia_reg;
                2'd1:    tan_waddr = ib_reg;
                default: tan_waddr = ic_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            strobe_reg <= 1'b0;
            k_reg      <= '0;
            wr_reg     <= '0;
            step_reg   <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(VERTEX_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        ia_reg <= slot(req.index_a);
                        ib_reg <= slot(req.index_b);
                        ic_reg <= slot(req.index_c);
                        if (req.req_type == ttuv_pkg::REQ_TRI)
                            state_reg <= S_RD_A;
                        else if (req.req_type == ttuv_pkg::REQ_READ)
                        begin
                            ia_reg    <= slot(req.vertex_index);
                            state_reg <= S_RD_T;
                        end
                    end
                end
                S_RD_T:
                begin
                    res_reg    <= {tan_q[95:64], tan_q[63:32], tan_q[31:0], 2'b00};
                    strobe_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                S_RD_A: state_reg <= S_RD_B;
                S_RD_B:
                begin
                    pa_reg[0] <= pos_q[47:32];
                    pa_reg[1] <= pos_q[31:16];
                    pa_reg[2] <= pos_q[15:0];
                    ua_reg    <= tex_q[31:16];
                    va_reg    <= tex_q[15:0];
                    state_reg <= S_RD_C;
                end
                S_RD_C:
                begin
                    pb_reg[0] <= pos_q[47:32];
                    pb_reg[1] <= pos_q[31:16];
                    pb_reg[2] <= pos_q[15:0];
                    ub_reg    <= tex_q[31:16];
                    vb_reg    <= tex_q[15:0];
                    state_reg <= S_GET_C;
                end
                S_GET_C:
                begin
                    d1u_reg <= 17'(ub_reg) - 17'(ua_reg);
                    d1v_reg <= 17'(vb_reg) - 17'(va_reg);
                    d2u_reg <= 17'(signed'(tex_q[31:16])) - 17'(ua_reg);
                    d2v_reg <= 17'(signed'(tex_q[15:0])) - 17'(va_reg);
                    for (int i = 0; i < 3; i++)
                    begin
                        e1_reg[i] <= 17'(pb_reg[i]) - 17'(pa_reg[i]);
                        e2_reg[i] <= 17'(signed'(pos_q[47-16*i -: 16])) - 17'(pa_reg[i]);
                    end
                    step_reg  <= '0;
                    state_reg <= S_DET;
                end
                S_DET:
                begin
                    // two products, then subtract
                    if (step_reg == 2'd0)
                    begin
                        m1_reg   <= 34'(d1u_reg * d2v_reg);
                        m2_reg   <= 34'(d2u_reg * d1v_reg);
                        step_reg <= 2'd1;
                    end
                    else
                    begin
                        det_reg   <= 33'(m1_reg - m2_reg);
                        sat_reg   <= 1'b0;
                        k_reg     <= '0;
                        step_reg  <= '0;
                        degen_reg <= (m1_reg == m2_reg);
                        if (m1_reg == m2_reg)
                        begin
                            t_reg[0]  <= '0;
                            t_reg[1]  <= '0;
                            t_reg[2]  <= '0;
                            wr_reg    <= '0;
                            state_reg <= S_WR;
                        end
                        else
                            state_reg <= S_NUM;
                    end
                end
                S_NUM:
                begin
                    if (step_reg == 2'd0)
                    begin
                        m1_reg   <= 34'(d2v_reg * e1_reg[k_reg]);
                        m2_reg   <= 34'(d1v_reg * e2_reg[k_reg]);
                        step_reg <= 2'd1;
                    end
                    else
                    begin
                        num_reg   <= 49'(m1_reg) - 49'(m2_reg);
                        step_reg  <= '0;
                        state_reg <= S_DIV_GO;
                    end
                end
                S_DIV_GO: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        t_reg[k_reg] <= div_q;
                        sat_reg      <= sat_reg | div_sat;
                        if (k_reg == 2'd2)
                        begin
                            wr_reg    <= '0;
                            state_reg <= S_WR;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_NUM;
                        end
                    end
                end
                S_WR:
                begin
                    wr_reg <= wr_reg + 2'd1;
                    if (wr_reg == 2'd2)
                    begin
                        res_reg    <= {t_reg[0], t_reg[1], t_reg[2], degen_reg, sat_reg};
                        strobe_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

`ifndef NO_ASSERTIONS
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (state_reg == S_IDLE)) else $error("result outside idle");
    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |=> !strobe_reg) else $error("double result");
    a_degen_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> !(res_reg.degenerate && res_reg.saturated))
        else $error("degenerate and saturated");
    a_div_only_num: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT)) else $error("stray divide");
`endif
endmodule
`default_nettype wire
